@@ design/rmsq_pkg.sv @@
// Shared types, codes and defaults for the range-minimum sparse-table unit.
`timescale 1ns / 1ps

package rmsq_pkg;

    // Default sizing of the table.
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;
    localparam int VALUE_WIDTH_DEF  = 24;

    // Element count after reset, before the parameter clamp.
    localparam int COUNT_RESET = 1024;

    // Fixed field widths of the words on the ports.
    localparam int OP_W    = 2;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 24;
    localparam int END_W   = 11;
    localparam int KIND_W  = 2;
    localparam int MIN_W   = 24;
    localparam int CFG_W   = 11;

    // Opcodes of an input word.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Kinds of a result word.
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic [END_W-1:0] first_end;
        logic [END_W-1:0] second_end;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MIN_W-1:0]  minimum;
    } t_out_word;

endpackage

@@ design/rmsq_table_mem.sv @@
// Table memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module rmsq_table_mem #(
    parameter int DEPTH  = 11264,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ design/range_minimum_sparse_table_unit.sv @@
// Top level of the range-minimum sparse-table unit: control, build walk and query path.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// --------  ---------  -------------------------  ------------------------------------
// input     in         i_valid / o_ready          i_word (opcode, position, value, ends)
// result    out        o_valid / i_ready          o_word (kind, minimum)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (element count)
//
// Load: written to level 0 of the table at accept. Query: check ends, read two blocks,
// then select into the result register; a rejected query skips the block reads.
// Build: top = min(floor(log2 n), LEVELS - 1) levels above level 0 for n elements,
// one entry per cycle plus a gap state per level for the last write of the level to land.
// Reset sets control, the count and the built mark only; the table holds nothing until loaded.
// Input is taken only while idle; a finished word waits in the output register.

module range_minimum_sparse_table_unit #(
    parameter int MAX_ELEMENTS = rmsq_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = rmsq_pkg::LEVELS_DEF,
    parameter int VALUE_WIDTH  = rmsq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rmsq_pkg::t_in_word            i_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rmsq_pkg::t_out_word           o_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmsq_pkg::CFG_W-1:0]    i_cfg_data
);

    // Element index, element count (holds MAX_ELEMENTS itself), level and address widths.
    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * (2 ** IDX_W);
    localparam int COUNT_RST = (rmsq_pkg::COUNT_RESET > MAX_ELEMENTS) ?
                               MAX_ELEMENTS : rmsq_pkg::COUNT_RESET;

    // Control states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QCHK = 3'd1;  // order and check the query ends
    localparam logic [2:0] S_QRD  = 3'd2;  // issue the two block reads
    localparam logic [2:0] S_BRD  = 3'd3;  // build: read one entry pair per cycle
    localparam logic [2:0] S_BGAP = 3'd4;  // build: let the last write of a level land
    localparam logic [2:0] S_OUT  = 3'd5;  // load the result into the output register

    // Priority encoder: index of the highest set bit, zero for zero.
    function automatic logic [4:0] floor_log2(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 1; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] level_cap(input logic [4:0] k);
        logic [LVL_W-1:0] r;
        if (32'(k) > LEVELS - 1) begin
            r = LVL_W'(LEVELS - 1);
        end else begin
            r = LVL_W'(k);
        end
        return r;
    endfunction

    logic [2:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_built, n_built;
    logic [LVL_W-1:0]             r_top, n_top;
    logic [LVL_W-1:0]             r_lvl, n_lvl;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [rmsq_pkg::END_W-1:0]   r_first, n_first;
    logic [rmsq_pkg::END_W-1:0]   r_second, n_second;
    logic [IDX_W-1:0]             r_lo, n_lo;
    logic [IDX_W-1:0]             r_hi, n_hi;
    logic [CNT_W-1:0]             r_span, n_span;
    logic [rmsq_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic                         r_wp, n_wp;
    logic [ADDR_W-1:0]            r_wp_addr, n_wp_addr;
    logic                         r_wp_use_b, n_wp_use_b;
    logic                         r_o_valid, n_o_valid;
    rmsq_pkg::t_out_word          r_o_word, n_o_word;

    logic                         accept;
    logic                         load_ok;
    logic                         mem_wr_en;
    logic [ADDR_W-1:0]            mem_wr_addr;
    logic [VALUE_WIDTH-1:0]       mem_wr_data;
    logic                         mem_rd_en;
    logic [ADDR_W-1:0]            mem_rd_addr_a;
    logic [ADDR_W-1:0]            mem_rd_addr_b;
    logic [VALUE_WIDTH-1:0]       mem_rd_data_a;
    logic [VALUE_WIDTH-1:0]       mem_rd_data_b;
    logic [VALUE_WIDTH-1:0]       pair_min;
    logic [VALUE_WIDTH-1:0]       build_data;
    logic [CNT_W-1:0]             half;
    logic [CNT_W-1:0]             partner;
    logic                         partner_ok;
    logic                         last_idx;
    logic [LVL_W-1:0]             lvl_below;
    logic [LVL_W-1:0]             q_level;
    logic [CNT_W-1:0]             q_block;
    logic [IDX_W-1:0]             q_right;
    logic                         q_reject;
    logic [rmsq_pkg::END_W-1:0]   q_lo_end;
    logic [rmsq_pkg::END_W-1:0]   q_hi_end;
    logic [rmsq_pkg::CFG_W-1:0]   cfg_val;
    logic                         out_free;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign load_ok     = accept && (i_word.opcode == rmsq_pkg::OP_LOAD) &&
                         (32'(i_word.position) < MAX_ELEMENTS);
    assign out_free    = !r_o_valid || i_ready;
    assign cfg_val     = i_cfg_data;

    // Build walk: entry idx of the level below and its partner half a block away.
    assign lvl_below  = LVL_W'(r_lvl - 1'b1);
    assign half       = CNT_W'(1) << lvl_below;
    assign partner    = CNT_W'(r_idx) + half;
    assign partner_ok = (partner < r_count);
    assign last_idx   = (CNT_W'(r_idx) == CNT_W'(r_count - 1'b1));

    // Query: level from the span, right block ends at the high end.
    assign q_level = level_cap(floor_log2(32'(r_span)));
    assign q_block = CNT_W'(1) << q_level;
    assign q_right = IDX_W'(CNT_W'(r_hi) + CNT_W'(1) - q_block);

    assign q_reject = !r_built || (r_first == '0) || (r_second == '0) ||
                      (32'(r_first) > 32'(r_count)) || (32'(r_second) > 32'(r_count));
    assign q_lo_end = (r_first <= r_second) ? r_first : r_second;
    assign q_hi_end = (r_first <= r_second) ? r_second : r_first;

    assign pair_min   = (mem_rd_data_a <= mem_rd_data_b) ? mem_rd_data_a : mem_rd_data_b;
    assign build_data = r_wp_use_b ? pair_min : mem_rd_data_a;

    // A pending build write has the port; a load only happens while idle.
    always_comb begin
        mem_wr_en   = r_wp || load_ok;
        mem_wr_addr = {LVL_W'(0), IDX_W'(i_word.position)};
        mem_wr_data = VALUE_WIDTH'(i_word.value);
        if (r_wp) begin
            mem_wr_addr = r_wp_addr;
            mem_wr_data = build_data;
        end
    end

    always_comb begin
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = {lvl_below, r_idx};
        mem_rd_addr_b = {lvl_below, partner[IDX_W-1:0]};
        if (r_state == S_BRD) begin
            mem_rd_en = 1'b1;
        end else if (r_state == S_QRD) begin
            mem_rd_en     = 1'b1;
            mem_rd_addr_a = {q_level, r_lo};
            mem_rd_addr_b = {q_level, q_right};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_built    = r_built;
        n_top      = r_top;
        n_lvl      = r_lvl;
        n_idx      = r_idx;
        n_first    = r_first;
        n_second   = r_second;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_span     = r_span;
        n_kind     = r_kind;
        n_wp       = 1'b0;
        n_wp_addr  = r_wp_addr;
        n_wp_use_b = r_wp_use_b;
        n_o_valid  = r_o_valid;
        n_o_word   = r_o_word;

        // Drop the result word once taken.
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_word.opcode)
                        rmsq_pkg::OP_LOAD: begin
                            if (load_ok) begin
                                n_built = 1'b0;
                            end
                        end
                        rmsq_pkg::OP_BUILD: begin
                            n_top = level_cap(floor_log2(32'(r_count)));
                            n_lvl = LVL_W'(1);
                            n_idx = '0;
                            if (n_top == '0) begin
                                n_kind  = rmsq_pkg::KIND_DONE;
                                n_built = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_BRD;
                            end
                        end
                        rmsq_pkg::OP_QUERY: begin
                            n_first  = i_word.first_end;
                            n_second = i_word.second_end;
                            n_state  = S_QCHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QCHK: begin
                n_lo   = IDX_W'(q_lo_end - 1'b1);
                n_hi   = IDX_W'(q_hi_end - 1'b1);
                n_span = CNT_W'(12'(q_hi_end) - 12'(q_lo_end) + 12'd1);
                if (q_reject) begin
                    n_kind  = rmsq_pkg::KIND_REJECT;
                    n_state = S_OUT;
                end else begin
                    n_kind  = rmsq_pkg::KIND_ANSWER;
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                n_state = S_OUT;
            end
            S_BRD: begin
                // Write the result back in the next cycle, when the read data is in.
                n_wp       = 1'b1;
                n_wp_addr  = {r_lvl, r_idx};
                n_wp_use_b = partner_ok;
                if (last_idx) begin
                    n_state = S_BGAP;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_BGAP: begin
                if (r_lvl == r_top) begin
                    n_kind  = rmsq_pkg::KIND_DONE;
                    n_built = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_lvl   = LVL_W'(r_lvl + 1'b1);
                    n_idx   = '0;
                    n_state = S_BRD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_o_valid      = 1'b1;
                    n_o_word.kind  = r_kind;
                    n_o_word.minimum = (r_kind == rmsq_pkg::KIND_ANSWER) ?
                                       rmsq_pkg::MIN_W'(pair_min) : '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A count write clamps to one through the table size and drops the built mark.
        if (i_cfg_valid) begin
            if (cfg_val == '0) begin
                n_count = CNT_W'(1);
            end else if (32'(cfg_val) > MAX_ELEMENTS) begin
                n_count = CNT_W'(MAX_ELEMENTS);
            end else begin
                n_count = CNT_W'(cfg_val);
            end
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= CNT_W'(COUNT_RST);
            r_built   <= 1'b0;
            r_wp      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_built   <= n_built;
            r_wp      <= n_wp;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload and walk registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_first    <= n_first;
        r_second   <= n_second;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_span     <= n_span;
        r_kind     <= n_kind;
        r_wp_addr  <= n_wp_addr;
        r_wp_use_b <= n_wp_use_b;
        r_o_word   <= n_o_word;
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

    rmsq_table_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_rd_en     (mem_rd_en),
        .i_rd_addr_a (mem_rd_addr_a),
        .i_rd_addr_b (mem_rd_addr_b),
        .o_rd_data_a (mem_rd_data_a),
        .o_rd_data_b (mem_rd_data_b)
    );

endmodule
